// ===== hdl/pgsc_pkg.sv =====
package pgsc_pkg;

   // default CORDIC iteration count
   localparam int CORDIC_STEPS_DEF = 24;

   // datapath widths
   localparam int GUARD_BITS = 8;
   localparam int CX_W       = 44;   // CORDIC x/y working width, signed
   localparam int CZ_W       = 32;   // angle accumulator, Q2.30 signed
   localparam int MAG_W      = 43;   // clamped CORDIC magnitude, unsigned
   localparam int MUL_W      = 33;   // shared multiplier operand width, signed
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 68;
   localparam int RHO_W      = 33;

   // fixed-point constants
   localparam logic [19:0]        INV_GAIN_Q20 = 20'd636751;
   localparam logic signed [18:0] HALF_PI_Q16  = 19'sd102944;
   localparam logic signed [20:0] WRAP_STEP_Q  = 21'sd205783;
   localparam logic signed [20:0] WRAP_HALF_Q  = 21'sd102892;

   // register map
   typedef enum logic [2:0] {
      REG_GOAL_X     = 3'd0,
      REG_GOAL_Y     = 3'd1,
      REG_GOAL_ANGLE = 3'd2,
      REG_GAIN_RHO   = 3'd3,
      REG_GAIN_ALPHA = 3'd4,
      REG_GAIN_PHI   = 3'd5
   } reg_index_type;

   // accumulate shift select
   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_16 = 2'd1,
      SH_22 = 2'd2
   } shift_sel_type;

   typedef struct packed {
      logic          issue;   // capture a*b
      logic          accum;   // add shifted product into accumulator
      logic          clear;   // start a fresh sum
      shift_sel_type sh;
   } mac_ctrl_type;

   // atan(2^-i) in Q2.30, truncated but for i = 0 and i = 27 to 30, which are rounded up
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/polar_goal_steering_controller.sv =====
// One transaction at a time: the CORDIC iterations and six passes through the single
// shared 33x33 multiplier run in turn before the next transaction is accepted.
// req_stall is high from acceptance until the result sits in the output register.
// Reset (synchronous, active high) clears control state and loads the register defaults.
module polar_goal_steering_controller #(
   parameter int CORDIC_STEPS = pgsc_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // pose input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_time_stamp,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [19:0] req_heading,
   input  logic        req_final_sample,
   // command output channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_time,
   output logic [31:0] rsp_velocity_cmd,
   output logic [31:0] rsp_turn_rate_cmd,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Sequencer: one-hot. A transaction walks DIFF -> LOAD -> CORDIC -> POST,
   // then six multiply/accumulate passes (MUL, ACC) with a TAKE after the first
   // two pairs; after the third, DONE hands the command to the output register.
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DIFF   = 9'b000000010,
      S_LOAD   = 9'b000000100,
      S_CORDIC = 9'b000001000,
      S_POST   = 9'b000010000,
      S_MUL    = 9'b000100000,
      S_ACC    = 9'b001000000,
      S_TAKE   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   // multiplier passes, in order; odd codes close a sum
   typedef enum logic [2:0] {
      OP_RHO_LO = 3'd0,   // cx[21:0]  * 1/K
      OP_RHO_HI = 3'd1,   // cx[42:22] * 1/K, << 22
      OP_VEL_LO = 3'd2,   // |k_rho| * rho[15:0]
      OP_VEL_HI = 3'd3,   // |k_rho| * rho[32:16], << 16
      OP_ALPHA  = 3'd4,   // k_alpha * alpha
      OP_PHI    = 3'd5    // k_phi * phi
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff;

   // configuration registers
   logic signed [31:0] goal_x_ff, goal_y_ff, gain_rho_ff, gain_alpha_ff, gain_phi_ff;
   logic signed [19:0] goal_angle_ff;

   // captured transaction
   logic [31:0]        time_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic signed [19:0] heading_ff;
   logic               last_ff;

   // working registers
   logic signed [32:0] dx_ff, dy_ff, abs_dx, abs_dy;
   logic signed [20:0] phi_ff, alpha_ff;
   logic signed [32:0] kr_abs_ff;
   logic [pgsc_pkg::RHO_W-1:0] rho_ff;
   logic [31:0]        vel_ff;

   // output register
   logic               rsp_valid_ff;
   logic [31:0]        rsp_time_ff, rsp_vel_ff, rsp_turn_ff;
   logic               rsp_last_ff;
   logic               rsp_load;

   // CORDIC and MAC hookup
   logic                                cordic_start, cordic_done;
   logic [pgsc_pkg::MAG_W-1:0]          cordic_mag;
   logic signed [pgsc_pkg::CZ_W-1:0]    cordic_angle;
   pgsc_pkg::mac_ctrl_type              mac_ctrl;
   logic signed [pgsc_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [pgsc_pkg::ACC_W-1:0]   acc;

   // post-processing
   logic signed [32:0] cz_round;
   logic signed [32:0] cz_shr;
   logic signed [18:0] atn_mag, atn;
   logic signed [pgsc_pkg::ACC_W-1:0] acc_rho, acc_rnd;
   logic [pgsc_pkg::ACC_W-17:0] vel_mag;
   logic               vel_over;
   logic [31:0]        vel_val, turn_val;
   logic               turn_in_range;

   logic req_take;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;   // writes must arrive only while idle; the block itself does not enforce this

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff     <= 32'sd65536;
         goal_y_ff     <= 32'sd65536;
         goal_angle_ff <= 20'sd51446;
         gain_rho_ff   <= 32'sd65536;
         gain_alpha_ff <= 32'sd65536;
         gain_phi_ff   <= 32'sd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pgsc_pkg::REG_GOAL_X:     goal_x_ff     <= csr_wdata;
            pgsc_pkg::REG_GOAL_Y:     goal_y_ff     <= csr_wdata;
            pgsc_pkg::REG_GOAL_ANGLE: goal_angle_ff <= csr_wdata[19:0];
            pgsc_pkg::REG_GAIN_RHO:   gain_rho_ff   <= csr_wdata;
            pgsc_pkg::REG_GAIN_ALPHA: gain_alpha_ff <= csr_wdata;
            pgsc_pkg::REG_GAIN_PHI:   gain_phi_ff   <= csr_wdata;
            default: ;   // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_take) state_in = S_DIFF;
         S_DIFF:   state_in = S_LOAD;
         S_LOAD:   state_in = S_CORDIC;
         S_CORDIC: if (cordic_done) state_in = S_POST;
         S_POST:   state_in = S_MUL;
         S_MUL:    state_in = S_ACC;
         S_ACC: begin
            if (op_ff == OP_PHI) begin
               state_in = S_DONE;
            end else if (op_ff[0]) begin
               state_in = S_TAKE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_TAKE:   state_in = S_MUL;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_RHO_LO;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_POST) begin
            op_ff <= OP_RHO_LO;
         end else if ((state_ff == S_TAKE) ||
                      ((state_ff == S_ACC) && !op_ff[0])) begin
            op_ff <= op_type'(op_ff + 3'd1);
         end
      end
   end

   // ---------------------------------------------------------------
   // Capture and front-end arithmetic
   // ---------------------------------------------------------------
   assign abs_dx = dx_ff[32] ? -dx_ff : dx_ff;
   assign abs_dy = dy_ff[32] ? -dy_ff : dy_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         time_ff    <= req_time_stamp;
         pos_x_ff   <= req_pos_x;
         pos_y_ff   <= req_pos_y;
         heading_ff <= req_heading;
         last_ff    <= req_final_sample;
      end
      if (state_ff == S_DIFF) begin
         dx_ff  <= {goal_x_ff[31], goal_x_ff} - {pos_x_ff[31], pos_x_ff};
         dy_ff  <= {goal_y_ff[31], goal_y_ff} - {pos_y_ff[31], pos_y_ff};
         phi_ff <= {goal_angle_ff[19], goal_angle_ff} - {heading_ff[19], heading_ff};
      end else if ((state_ff == S_LOAD) || (state_ff == S_CORDIC)) begin
         // heading error fold: one 3.14 step per cycle, done long before the CORDIC
         if (phi_ff < -pgsc_pkg::WRAP_HALF_Q) begin
            phi_ff <= phi_ff + pgsc_pkg::WRAP_STEP_Q;
         end else if (phi_ff > pgsc_pkg::WRAP_HALF_Q) begin
            phi_ff <= phi_ff - pgsc_pkg::WRAP_STEP_Q;
         end
      end
   end

   assign cordic_start = (state_ff == S_LOAD);

   pgsc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .abs_x  (abs_dx[31:0]),
      .abs_y  (abs_dy[31:0]),
      .done   (cordic_done),
      .mag    (cordic_mag),
      .angle  (cordic_angle)
   );

   // bearing: Q2.30 -> Q16.16 round half up, then the quadrant sign and
   // the axis cases (dx zero gives 0, dy zero gives +-pi/2)
   assign cz_round = {cordic_angle[pgsc_pkg::CZ_W-1], cordic_angle} + 33'sd8192;
   assign cz_shr   = cz_round >>> 14;
   assign atn_mag  = cz_shr[18:0];

   always_comb begin
      if (dx_ff == '0) begin
         atn = '0;
      end else if (dy_ff == '0) begin
         atn = dx_ff[32] ? -pgsc_pkg::HALF_PI_Q16 : pgsc_pkg::HALF_PI_Q16;
      end else if (dx_ff[32] != dy_ff[32]) begin
         atn = -atn_mag;
      end else begin
         atn = atn_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_POST) begin
         alpha_ff  <= {{2{atn[18]}}, atn} - {heading_ff[19], heading_ff};
         kr_abs_ff <= gain_rho_ff[31] ? -{gain_rho_ff[31], gain_rho_ff}
                                      : {gain_rho_ff[31], gain_rho_ff};
      end
   end

   // ---------------------------------------------------------------
   // Shared multiplier: operand select and control
   // ---------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_RHO_LO: begin
            mul_a = $signed({11'b0, cordic_mag[21:0]});
            mul_b = $signed({13'b0, pgsc_pkg::INV_GAIN_Q20});
         end
         OP_RHO_HI: begin
            mul_a = $signed({12'b0, cordic_mag[42:22]});
            mul_b = $signed({13'b0, pgsc_pkg::INV_GAIN_Q20});
         end
         OP_VEL_LO: begin
            mul_a = kr_abs_ff;
            mul_b = $signed({17'b0, rho_ff[15:0]});
         end
         OP_VEL_HI: begin
            mul_a = kr_abs_ff;
            mul_b = $signed({16'b0, rho_ff[32:16]});
         end
         OP_ALPHA: begin
            mul_a = {gain_alpha_ff[31], gain_alpha_ff};
            mul_b = {{12{alpha_ff[20]}}, alpha_ff};
         end
         OP_PHI: begin
            mul_a = {gain_phi_ff[31], gain_phi_ff};
            mul_b = {{12{phi_ff[20]}}, phi_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      mac_ctrl.issue = (state_ff == S_MUL);
      mac_ctrl.accum = (state_ff == S_ACC);
      mac_ctrl.clear = !op_ff[0];
      case (op_ff)
         OP_RHO_HI: mac_ctrl.sh = pgsc_pkg::SH_22;
         OP_VEL_HI: mac_ctrl.sh = pgsc_pkg::SH_16;
         default:   mac_ctrl.sh = pgsc_pkg::SH_0;
      endcase
   end

   pgsc_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .acc   (acc)
   );

   // ---------------------------------------------------------------
   // Result shaping
   // ---------------------------------------------------------------
   // rho = (cx * 1/K + 2^27) >> 28, sum is non-negative
   assign acc_rho = acc + (pgsc_pkg::ACC_W'(1) <<< 27);
   // shared Q32.32 -> Q16.16 round half up for velocity and turn rate
   assign acc_rnd = acc + pgsc_pkg::ACC_W'(32768);

   // velocity: magnitude rounded, clamped, then signed by k_rho
   assign vel_mag  = acc_rnd[pgsc_pkg::ACC_W-1:16];
   assign vel_over = |vel_mag[pgsc_pkg::ACC_W-17:31];

   always_comb begin
      if (kr_abs_ff == '0) begin
         vel_val = '0;
      end else if (gain_rho_ff[31]) begin
         vel_val = vel_over ? 32'h8000_0000 : -vel_mag[31:0];
      end else begin
         vel_val = vel_over ? 32'h7FFF_FFFF : vel_mag[31:0];
      end
   end

   // turn rate: in range when the bits above bit 31 repeat the sign
   assign turn_in_range = (acc_rnd[pgsc_pkg::ACC_W-1:47] == '0) ||
                          (acc_rnd[pgsc_pkg::ACC_W-1:47] == '1);

   always_comb begin
      if (turn_in_range) begin
         turn_val = acc_rnd[47:16];
      end else if (acc_rnd[pgsc_pkg::ACC_W-1]) begin
         turn_val = 32'h8000_0000;
      end else begin
         turn_val = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_TAKE) begin
         if (op_ff == OP_RHO_HI) begin
            rho_ff <= acc_rho[pgsc_pkg::RHO_W+27:28];
         end
         if (op_ff == OP_VEL_HI) begin
            vel_ff <= vel_val;
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register: holds a finished transaction while rsp_stall is high
   // ---------------------------------------------------------------
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_time_ff <= time_ff;
         rsp_vel_ff  <= vel_ff;
         rsp_turn_ff <= turn_val;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_time      = rsp_time_ff;
   assign rsp_velocity_cmd  = rsp_vel_ff;
   assign rsp_turn_rate_cmd = rsp_turn_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef ASSERT_OFF
   // a new command appears only straight after the sequencer finished one
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("command raised without a finished transaction");

   // CORDIC completion only expected while the sequencer waits for it
   a_cordic_done_in_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == S_CORDIC))
      else $error("CORDIC finished outside its wait state");

   // the multiplier pass index stays within the six passes
   a_op_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL) || (state_ff == S_ACC)) |-> (op_ff <= OP_PHI))
      else $error("multiplier pass index out of range");

   // an accepted transaction starts the difference stage next cycle
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_DIFF))
      else $error("accepted transaction did not start");
`endif

endmodule

// ===== hdl/pgsc_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per cycle.
module pgsc_cordic #(
   parameter int CORDIC_STEPS = pgsc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         abs_x,
   input  logic [31:0]                         abs_y,
   output logic                                done,
   output logic [pgsc_pkg::MAG_W-1:0]          mag,
   output logic signed [pgsc_pkg::CZ_W-1:0]    angle
);

   localparam int CntW = $clog2(CORDIC_STEPS + 1);

   logic signed [pgsc_pkg::CX_W-1:0] cx_ff, cy_ff, xs, ys;
   logic signed [pgsc_pkg::CZ_W-1:0] cz_ff, rot;
   logic [CntW-1:0]                  cnt_ff;
   logic                             run_ff;
   logic [5:0]                       iter;
   logic                             last_iter;

   assign iter      = 6'(cnt_ff);
   assign last_iter = (cnt_ff == CntW'(CORDIC_STEPS - 1));
   assign xs        = cx_ff >>> iter;
   assign ys        = cy_ff >>> iter;
   assign rot       = $signed({2'b00, pgsc_pkg::atan_q30(iter[4:0])});
   assign done      = run_ff && last_iter;

   // x starts on |dy|, y on |dx|, each with guard bits
   always_ff @(posedge clock) begin
      if (start) begin
         cx_ff <= pgsc_pkg::CX_W'({abs_y, 8'h00});
         cy_ff <= pgsc_pkg::CX_W'({abs_x, 8'h00});
         cz_ff <= '0;
      end else if (run_ff) begin
         if (!cy_ff[pgsc_pkg::CX_W-1]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + rot;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - rot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + CntW'(1);
         if (last_iter) begin
            run_ff <= 1'b0;
         end
      end
   end

   assign mag   = cx_ff[pgsc_pkg::CX_W-1] ? '0 : cx_ff[pgsc_pkg::MAG_W-1:0];
   assign angle = cz_ff;

endmodule

// ===== hdl/pgsc_mac.sv =====
// Shared multiply-accumulate: registered product, then shifted accumulate.
module pgsc_mac (
   input  logic                                 clock,
   input  pgsc_pkg::mac_ctrl_type               ctrl,
   input  logic signed [pgsc_pkg::MUL_W-1:0]    op_a,
   input  logic signed [pgsc_pkg::MUL_W-1:0]    op_b,
   output logic signed [pgsc_pkg::ACC_W-1:0]    acc
);

   logic signed [pgsc_pkg::PROD_W-1:0] prod_ff;
   logic signed [pgsc_pkg::ACC_W-1:0]  acc_ff, prod_ext, shifted, base;

   assign prod_ext = {{(pgsc_pkg::ACC_W - pgsc_pkg::PROD_W){prod_ff[pgsc_pkg::PROD_W-1]}},
                      prod_ff};

   always_comb begin
      case (ctrl.sh)
         pgsc_pkg::SH_16: shifted = prod_ext <<< 16;
         pgsc_pkg::SH_22: shifted = prod_ext <<< 22;
         default:         shifted = prod_ext;
      endcase
      base = ctrl.clear ? '0 : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff <= op_a * op_b;
      end
      if (ctrl.accum) begin
         acc_ff <= base + shifted;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== verif/tb_polar_goal_steering_controller.sv =====
`timescale 1ns / 1ps

package steering_check_pkg;

   localparam int     GUARD        = 8;
   localparam longint RHO_SCALE    = 636751;      // 1/K, Q0.20
   localparam longint RHO_ROUND    = 134217728;   // half of 2^28
   localparam longint QUARTER_TURN = 102944;      // pi/2, Q16.16
   localparam longint FOLD_STEP    = 205783;      // 3.14
   localparam longint FOLD_LIMIT   = 102892;      // 1.57
   localparam longint SAT_HI       = 64'sd2147483647;
   localparam longint SAT_LO       = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic [31:0]        time_stamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [19:0] heading;
      logic               final_sample;
   } pose_type;

   typedef struct packed {
      logic [31:0] out_time;
      logic [31:0] velocity_cmd;
      logic [31:0] turn_rate_cmd;
      logic        last;
   } cmd_type;

   class command_ledger;
      logic signed [31:0] goal_x, goal_y, gain_rho, gain_alpha, gain_phi;
      logic signed [19:0] goal_angle;
      longint             atan_steps[32];
      cmd_type            queued_commands[$];
      int                 mismatches;
      int                 steps;

      function new(int cordic_steps);
         steps      = cordic_steps;
         mismatches = 0;
         goal_x     = 32'sd65536;
         goal_y     = 32'sd65536;
         goal_angle = 20'sd51446;
         gain_rho   = 32'sd65536;
         gain_alpha = 32'sd65536;
         gain_phi   = 32'sd65536;
         atan_steps = '{843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                        127, 63, 31, 15, 8, 4, 2, 1, 0};
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            pgsc_pkg::REG_GOAL_X:     goal_x     = data;
            pgsc_pkg::REG_GOAL_Y:     goal_y     = data;
            pgsc_pkg::REG_GOAL_ANGLE: goal_angle = data[19:0];
            pgsc_pkg::REG_GAIN_RHO:   gain_rho   = data;
            pgsc_pkg::REG_GAIN_ALPHA: gain_alpha = data;
            pgsc_pkg::REG_GAIN_PHI:   gain_phi   = data;
            default: ;   // unmapped, dropped
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > SAT_HI) return SAT_HI;
         if (v < SAT_LO) return SAT_LO;
         return v;
      endfunction

      function cmd_type steer_law(pose_type p);
         longint dx, dy, cx, cy, cz, xs, ys, hd, rho, atn, phi, alpha, vel, omega, kr, kmag;
         longint unsigned mag;
         cmd_type c;
         hd = $signed(p.heading);
         dx = longint'(goal_x) - longint'($signed(p.pos_x));
         dy = longint'(goal_y) - longint'($signed(p.pos_y));
         cx = (dy < 0 ? -dy : dy) <<< GUARD;
         cy = (dx < 0 ? -dx : dx) <<< GUARD;
         cz = 0;
         for (int i = 0; i < steps && i < 32; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0) begin
               cx += ys;
               cy -= xs;
               cz += atan_steps[i];
            end else begin
               cx -= ys;
               cy += xs;
               cz -= atan_steps[i];
            end
         end
         if (cx < 0) cx = 0;
         rho = (cx * RHO_SCALE + RHO_ROUND) >>> (20 + GUARD);

         if (dx == 0) begin
            atn = 0;
         end else if (dy == 0) begin
            atn = dx > 0 ? QUARTER_TURN : -QUARTER_TURN;
         end else begin
            atn = (cz + 8192) >>> 14;
            if ((dx < 0) != (dy < 0)) atn = -atn;
         end

         phi = longint'(goal_angle) - hd;
         while (phi < -FOLD_LIMIT) phi += FOLD_STEP;
         while (phi > FOLD_LIMIT) phi -= FOLD_STEP;
         alpha = atn - hd;

         kr   = longint'(gain_rho);
         kmag = kr < 0 ? -kr : kr;
         mag  = $unsigned(kmag) * $unsigned(rho);
         mag  = (mag + 64'd32768) >> 16;
         if (mag > 64'd2147483648) mag = 64'd2147483648;
         vel = kr < 0 ? -$signed(mag) : $signed(mag);
         vel = clamp32(vel);

         omega = clamp32((longint'(gain_alpha) * alpha + longint'(gain_phi) * phi
                          + 64'sd32768) >>> 16);

         c.out_time      = p.time_stamp;
         c.velocity_cmd  = vel[31:0];
         c.turn_rate_cmd = omega[31:0];
         c.last          = p.final_sample;
         return c;
      endfunction

      function void log_pose(pose_type p);
         queued_commands.push_back(steer_law(p));
      endfunction

      function int pending();
         return queued_commands.size();
      endfunction

      function void check_command(cmd_type got);
         cmd_type want;
         if (queued_commands.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t unexpected command: t=%h v=%h w=%h l=%b", $realtime,
                        got.out_time, got.velocity_cmd, got.turn_rate_cmd, got.last);
            return;
         end
         want = queued_commands.pop_front();
         if (got.out_time !== want.out_time || got.velocity_cmd !== want.velocity_cmd ||
             got.turn_rate_cmd !== want.turn_rate_cmd || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t command mismatch: want t=%h v=%h w=%h l=%b, got t=%h v=%h w=%h l=%b",
                        $realtime, want.out_time, want.velocity_cmd, want.turn_rate_cmd,
                        want.last, got.out_time, got.velocity_cmd, got.turn_rate_cmd, got.last);
         end
      endfunction
   endclass

endpackage

module tb_polar_goal_steering_controller;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = pgsc_pkg::CORDIC_STEPS_DEF + 40;   // beyond the block's latency
   localparam int PHASES      = 7;
   localparam int PHASE_POSES = 250;

   // indices past the register map: writes there must change nothing
   localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
   localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

   localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN  = 32'h8000_FFFF & 32'h8000_0000;
   localparam logic [31:0] ONE_M  = 32'd65536;
   localparam logic [19:0] HD_MAX = 20'h7FFFF;
   localparam logic [19:0] HD_MIN = 20'h80000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_time_stamp = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [19:0] req_heading = '0;
   logic        req_final_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_time;
   logic [31:0] rsp_velocity_cmd;
   logic [31:0] rsp_turn_rate_cmd;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   steering_check_pkg::command_ledger ledger = new(pgsc_pkg::CORDIC_STEPS_DEF);

   // idling knobs, flipped in stretches by the stimulus
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int rx_hold = 0;   // one-off long hold-off for the command side

   polar_goal_steering_controller #(
      .CORDIC_STEPS(pgsc_pkg::CORDIC_STEPS_DEF)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_time_stamp   (req_time_stamp),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_heading      (req_heading),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_time     (rsp_out_time),
      .rsp_velocity_cmd (rsp_velocity_cmd),
      .rsp_turn_rate_cmd(rsp_turn_rate_cmd),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Pose transaction. Valid is left high on return so that a back-to-back
   // pose keeps it up without a second assignment in the same step.
   task automatic offer_pose(input steering_check_pkg::pose_type p);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_time_stamp   <= p.time_stamp;
      req_pos_x        <= p.pos_x;
      req_pos_y        <= p.pos_y;
      req_heading      <= p.heading;
      req_final_sample <= p.final_sample;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.log_pose(p);
   endtask

   // stop offering and wait for every outstanding command
   task automatic hold_for_drain();
      @(negedge clock) req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      ledger.write_reg(idx, data);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic steering_check_pkg::pose_type make_pose(
      logic [31:0] ts, logic [31:0] x, logic [31:0] y, logic [19:0] hd, logic fin);
      steering_check_pkg::pose_type p;
      p.time_stamp   = ts;
      p.pos_x        = x;
      p.pos_y        = y;
      p.heading      = hd;
      p.final_sample = fin;
      return p;
   endfunction

   // coordinate around a goal axis: on it, close, far, at an extreme, or anywhere at all
   function automatic logic [31:0] coord_near(logic [31:0] centre);
      case ($urandom_range(0, 9))
         0:       return centre;
         1:       return $urandom();
         2:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         3:       return centre + $urandom_range(0, 2047) - 32'd1024;
         4, 5:    return centre + $urandom_range(0, 1 << 21) - 32'd1048576;
         default: return centre + $urandom_range(0, 1 << 27) - 32'd67108864;
      endcase
   endfunction

   function automatic steering_check_pkg::pose_type rand_pose();
      logic [19:0] hd;
      case ($urandom_range(0, 9))
         0:       hd = HD_MAX;
         1:       hd = HD_MIN;
         default: hd = 20'($urandom());
      endcase
      return make_pose($urandom(), coord_near(ledger.goal_x), coord_near(ledger.goal_y),
                       hd, $urandom_range(0, 7) == 0);
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 9))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return $urandom();
         default: return $urandom_range(0, 1 << 19) - 32'd262144;   // within +-4.0
      endcase
   endfunction

   function automatic logic [31:0] rand_goal();
      case ($urandom_range(0, 7))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return $urandom();
         default: return $urandom_range(0, 1 << 24) - 32'd8388608;   // within +-128 m
      endcase
   endfunction

   // fresh settings for a phase; phase 0 zeroes gains and goal position, phase 1 pins the extremes
   task automatic reconfigure(input int phase);
      case (phase)
         0: begin
            set_reg(pgsc_pkg::REG_GAIN_RHO, '0);
            set_reg(pgsc_pkg::REG_GAIN_ALPHA, '0);
            set_reg(pgsc_pkg::REG_GAIN_PHI, '0);
            set_reg(pgsc_pkg::REG_GOAL_X, '0);
            set_reg(pgsc_pkg::REG_GOAL_Y, '0);
            set_reg(pgsc_pkg::REG_GOAL_ANGLE, {12'hFFF, HD_MIN});
         end
         1: begin
            set_reg(pgsc_pkg::REG_GAIN_RHO, Q_MIN);
            set_reg(pgsc_pkg::REG_GAIN_ALPHA, Q_MIN);
            set_reg(pgsc_pkg::REG_GAIN_PHI, Q_MIN);
            set_reg(pgsc_pkg::REG_GOAL_X, Q_MIN);
            set_reg(pgsc_pkg::REG_GOAL_Y, Q_MAX);
            set_reg(pgsc_pkg::REG_GOAL_ANGLE, {12'h000, HD_MAX});
         end
         default: begin
            set_reg(pgsc_pkg::REG_GOAL_X, rand_goal());
            set_reg(pgsc_pkg::REG_GOAL_Y, rand_goal());
            set_reg(pgsc_pkg::REG_GOAL_ANGLE, $urandom());
            set_reg(pgsc_pkg::REG_GAIN_RHO, rand_gain());
            set_reg(pgsc_pkg::REG_GAIN_ALPHA, rand_gain());
            set_reg(pgsc_pkg::REG_GAIN_PHI, rand_gain());
         end
      endcase
      if (phase == 3) begin
         set_reg(REG_UNMAPPED_A, $urandom());
         set_reg(REG_UNMAPPED_B, $urandom());
      end
   endtask

   // Command side: draw a hold-off per command, or take the long one if asked.
   initial begin : command_sink
      int                          hold;
      steering_check_pkg::cmd_type got;
      do @(posedge clock); while (reset);
      forever begin
         hold = rx_idle ? $urandom_range(0, 7) : 0;
         if (rx_hold > 0) begin
            hold    = rx_hold;
            rx_hold = 0;
         end
         if (hold > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.out_time      = rsp_out_time;
         got.velocity_cmd  = rsp_velocity_cmd;
         got.turn_rate_cmd = rsp_turn_rate_cmd;
         got.last          = rsp_last;
         ledger.check_command(got);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset settings: goal at (1,1), all gains 1.0.
      offer_pose(make_pose(32'h0, ONE_M, ONE_M, 20'd0, 1'b0));           // goal reached
      offer_pose(make_pose(32'hFFFF_FFFF, ONE_M, 32'd0, 20'd0, 1'b1));    // dx zero, goal ahead
      offer_pose(make_pose(32'd1, ONE_M, 32'd200000, HD_MAX, 1'b0));      // dx zero, goal behind
      offer_pose(make_pose(32'd2, 32'd0, ONE_M, HD_MIN, 1'b0));           // dy zero, dx positive
      offer_pose(make_pose(32'd3, 32'd200000, ONE_M, 20'd0, 1'b0));       // dy zero, dx negative
      // one per quadrant
      offer_pose(make_pose(32'd4, 32'd0, 32'd0, 20'd0, 1'b0));
      offer_pose(make_pose(32'd5, 32'd131072, 32'd0, 20'd0, 1'b0));
      offer_pose(make_pose(32'd6, 32'd0, 32'd131072, 20'd0, 1'b0));
      offer_pose(make_pose(32'd7, 32'd131072, 32'd131072, 20'd0, 1'b0));
      // far corners, heading extremes force the fold of the heading error
      offer_pose(make_pose(32'd8, Q_MAX, Q_MAX, HD_MAX, 1'b0));
      offer_pose(make_pose(32'd9, Q_MIN, Q_MIN, HD_MIN, 1'b0));
      offer_pose(make_pose(32'd10, Q_MIN, Q_MAX, 20'd1, 1'b1));
      // heading error right on the fold limits and just past one
      offer_pose(make_pose(32'hA5A5_A5A5, 32'hFFFD_0000, 32'h0007_0000, -20'sd51446, 1'b0));
      offer_pose(make_pose(32'h5A5A_5A5A, 32'd0, 32'd0, 20'sd154338, 1'b0));
      offer_pose(make_pose(32'd11, 32'd0, 32'd0, 20'sd154339, 1'b0));
      hold_for_drain();

      // Extreme settings; upper bits of the angle write must be dropped,
      // and writes past the map must leave everything alone.
      set_reg(pgsc_pkg::REG_GOAL_X, Q_MAX);
      set_reg(pgsc_pkg::REG_GOAL_Y, Q_MIN);
      set_reg(pgsc_pkg::REG_GOAL_ANGLE, {12'hABC, HD_MAX});
      set_reg(pgsc_pkg::REG_GAIN_RHO, Q_MAX);
      set_reg(pgsc_pkg::REG_GAIN_ALPHA, Q_MIN);
      set_reg(pgsc_pkg::REG_GAIN_PHI, Q_MAX);
      set_reg(REG_UNMAPPED_A, $urandom());
      set_reg(REG_UNMAPPED_B, '0);
      offer_pose(make_pose(32'd12, Q_MIN, Q_MAX, HD_MIN, 1'b0));   // longest distance
      offer_pose(make_pose(32'd13, Q_MAX, Q_MIN, 20'd0, 1'b0));    // on the goal
      offer_pose(make_pose(32'd14, Q_MAX, 32'd0, HD_MAX, 1'b0));   // dx zero
      offer_pose(make_pose(32'd15, 32'd0, Q_MIN, HD_MIN, 1'b1));   // dy zero, saturates
      offer_pose(rand_pose());
      hold_for_drain();
      set_reg(pgsc_pkg::REG_GAIN_RHO, Q_MIN);                      // negative saturation
      offer_pose(make_pose(32'd16, Q_MIN, Q_MAX, HD_MAX, 1'b0));
      offer_pose(make_pose(32'd17, 32'd0, 32'd0, 20'd0, 1'b0));

      // Random phases, each under its own settings.
      for (int phase = 0; phase < PHASES; phase++) begin
         hold_for_drain();
         reconfigure(phase);
         for (int n = 0; n < PHASE_POSES; n++) begin
            if (n % 50 == 0) begin
               tx_idle = $urandom_range(0, 3) != 0;
               rx_idle = $urandom_range(0, 3) != 0;
            end
            // long hold-off on the command side while poses keep coming
            if (phase == 2 && n == 100) rx_hold = 400;
            // and once, the pose side waits until the block is empty
            if (phase == 4 && n == 125) hold_for_drain();
            offer_pose(rand_pose());
         end
      end

      hold_for_drain();
      repeat (SETTLE) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/pgsc_pkg.sv
hdl/pgsc_cordic.sv
hdl/pgsc_mac.sv
hdl/polar_goal_steering_controller.sv
verif/tb_polar_goal_steering_controller.sv
